// File: hw/rtl/ibhn_pkg.sv
package ibhn_pkg;

  localparam int CFG_W   = 11;
  localparam int IDX_I_W = 10;
  localparam int PIX_W   = 32;
  localparam int RAD_W   = 16;
  localparam int R2_W    = 2 * RAD_W;
  localparam int BRT_W   = 16;
  localparam int WGT_W   = 48;
  localparam int DIV_N   = 64;
  localparam int FRAC_W  = 16;

  localparam logic [2:0] ACT_PIXEL  = 3'd0;
  localparam logic [2:0] ACT_RADIUS = 3'd1;
  localparam logic [2:0] ACT_SWEEP  = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [BRT_W-1:0] Q16_ONE = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_SW_RD,
    ST_SW_MUL,
    ST_SW_START,
    ST_SW_DIV,
    ST_SW_WR,
    ST_RD_CHK,
    ST_RD_DIV
  } state_t;

endpackage

// File: hw/rtl/id_buffer_hit_histogram_normalizer_top.sv
// Object-ID hit histogram with area and peak normalisation. A request is taken when start is
// high and busy is low; results appear for a single cycle on out_valid and the receiver cannot
// stall them, so it must take every strobe. Counters, radii and weights live in one-read
// one-write synchronous RAMs with registered read data. A pixel request reads its counter,
// then writes it back; a radius load is written straight from idle; a clear request and the
// clearing pass after reset write zero to every counter address. A read of an object outside
// the active range or before any non-zero peak answers straight from idle with zero, a
// full-scale read answers from the weight check, and any other read waits for the 64-step
// shared divider. A finish sweep reads, scales and writes back each active object in turn,
// skipping that divider for an object of zero radius. Configuration writes are always accepted.
module id_buffer_hit_histogram_normalizer_top #(
  parameter int MAX_OBJECTS = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic [ibhn_pkg::PIX_W-1:0]    in_pixel_word,
  input  logic [ibhn_pkg::IDX_I_W-1:0]  in_object_index,
  input  logic [ibhn_pkg::RAD_W-1:0]    in_radius,
  output logic                          out_valid,
  output logic [ibhn_pkg::IDX_I_W-1:0]  out_result_index,
  output logic [ibhn_pkg::BRT_W-1:0]    out_brightness,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ibhn_pkg::CFG_W-1:0]    cfg_object_count
);

  localparam int IDX_W = $clog2(MAX_OBJECTS);
  localparam int CFW   = ibhn_pkg::CFG_W;
  localparam int DN    = ibhn_pkg::DIV_N;
  localparam int WW    = ibhn_pkg::WGT_W;
  localparam int BW    = ibhn_pkg::BRT_W;
  localparam int R2W   = ibhn_pkg::R2_W;
  localparam int FW    = ibhn_pkg::FRAC_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_OBJECTS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_FULL = '1;
  localparam logic [WW-1:0] WGT_FULL = '1;

  ibhn_pkg::state_t state_r, state_nxt;

  logic [CFW-1:0]         obj_count_r;
  logic [IDX_W-1:0]       clr_idx_r;
  logic [IDX_W-1:0]       sw_idx_r;
  logic [IDX_W-1:0]       pix_addr_r;
  logic [ibhn_pkg::IDX_I_W-1:0] req_idx_r;
  logic [COUNT_WIDTH-1:0] cnt_val_r;
  logic [R2W-1:0]         r2_r;
  logic [WW-1:0]          weight_r;
  logic [WW-1:0]          max_weight_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [BW-1:0]          out_brt_r, out_brt_nxt;

  logic [CFW-1:0]         act;
  logic                   accept;
  logic [ibhn_pkg::PIX_W-1:0] pix_obj;
  logic                   pix_hit;
  logic                   rd_ok;
  logic                   rad_ok;
  logic                   sw_last;

  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   rad_we;
  logic [ibhn_pkg::RAD_W-1:0] rad_rdata;
  logic                   wgt_we;
  logic [WW-1:0]          wgt_rdata;

  logic                   div_start;
  logic [DN-1:0]          div_dividend;
  logic [WW-1:0]          div_divisor;
  logic                   div_done;
  logic [DN-1:0]          div_q;
  logic [DN-1:0]          w_ext;
  logic [WW-1:0]          q_sat;

  always_comb begin
    act     = (32'(obj_count_r) > 32'(MAX_OBJECTS)) ? CFW'(MAX_OBJECTS) : obj_count_r;
    accept  = start && !busy;
    pix_obj = in_pixel_word - 32'd1;
    pix_hit = (in_pixel_word != '0) && (pix_obj < 32'(act));
    rd_ok   = (CFW'(in_object_index) < act) && (max_weight_r != '0);
    rad_ok  = 32'(in_object_index) < 32'(MAX_OBJECTS);
    sw_last = (32'(sw_idx_r) + 32'd1) == 32'(act);
    w_ext   = DN'(wgt_rdata);
    q_sat   = (div_q[DN-1:WW] != '0) ? WGT_FULL : div_q[WW-1:0];
  end

  assign busy      = state_r != ibhn_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ibhn_pkg::ST_CLEAR: begin
        if (clr_idx_r == IDX_LAST) state_nxt = ibhn_pkg::ST_IDLE;
      end
      ibhn_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ibhn_pkg::ACT_PIXEL: if (pix_hit) state_nxt = ibhn_pkg::ST_PIX;
            ibhn_pkg::ACT_SWEEP: if (act != '0) state_nxt = ibhn_pkg::ST_SW_RD;
            ibhn_pkg::ACT_READ:  if (rd_ok) state_nxt = ibhn_pkg::ST_RD_CHK;
            ibhn_pkg::ACT_CLEAR: state_nxt = ibhn_pkg::ST_CLEAR;
            default:             state_nxt = ibhn_pkg::ST_IDLE;
          endcase
        end
      end
      ibhn_pkg::ST_PIX:      state_nxt = ibhn_pkg::ST_IDLE;
      ibhn_pkg::ST_SW_RD:    state_nxt = ibhn_pkg::ST_SW_MUL;
      ibhn_pkg::ST_SW_MUL:   state_nxt = ibhn_pkg::ST_SW_START;
      ibhn_pkg::ST_SW_START: begin
        state_nxt = (r2_r == '0) ? ibhn_pkg::ST_SW_WR : ibhn_pkg::ST_SW_DIV;
      end
      ibhn_pkg::ST_SW_DIV: begin
        if (div_done) state_nxt = ibhn_pkg::ST_SW_WR;
      end
      ibhn_pkg::ST_SW_WR: begin
        state_nxt = sw_last ? ibhn_pkg::ST_IDLE : ibhn_pkg::ST_SW_RD;
      end
      ibhn_pkg::ST_RD_CHK: begin
        state_nxt = (wgt_rdata >= max_weight_r) ? ibhn_pkg::ST_IDLE : ibhn_pkg::ST_RD_DIV;
      end
      ibhn_pkg::ST_RD_DIV: begin
        if (div_done) state_nxt = ibhn_pkg::ST_IDLE;
      end
      default: state_nxt = ibhn_pkg::ST_IDLE;
    endcase
  end

  // memory, divider and result control
  always_comb begin
    cnt_we        = 1'b0;
    cnt_waddr     = pix_addr_r;
    cnt_wdata     = cnt_rdata + COUNT_WIDTH'(1);
    cnt_raddr     = pix_obj[IDX_W-1:0];
    rad_we        = 1'b0;
    wgt_we        = 1'b0;
    div_start     = 1'b0;
    div_dividend  = DN'(cnt_val_r) << FW;
    div_divisor   = WW'(r2_r);
    out_valid_nxt = 1'b0;
    out_brt_nxt   = '0;
    case (state_r)
      ibhn_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_r;
        cnt_wdata = '0;
      end
      ibhn_pkg::ST_IDLE: begin
        if (accept && in_action == ibhn_pkg::ACT_RADIUS && rad_ok) rad_we = 1'b1;
        if (accept && in_action == ibhn_pkg::ACT_READ && !rd_ok) out_valid_nxt = 1'b1;
      end
      ibhn_pkg::ST_PIX: begin
        cnt_we = cnt_rdata != CNT_FULL;
      end
      ibhn_pkg::ST_SW_RD: begin
        cnt_raddr = sw_idx_r;
      end
      ibhn_pkg::ST_SW_START: begin
        div_start = r2_r != '0;
      end
      ibhn_pkg::ST_SW_WR: begin
        wgt_we = 1'b1;
      end
      ibhn_pkg::ST_RD_CHK: begin
        div_dividend = (w_ext << FW) - w_ext;
        div_divisor  = max_weight_r;
        if (wgt_rdata >= max_weight_r) begin
          out_valid_nxt = 1'b1;
          out_brt_nxt   = ibhn_pkg::Q16_ONE;
        end else begin
          div_start = 1'b1;
        end
      end
      ibhn_pkg::ST_RD_DIV: begin
        out_valid_nxt = div_done;
        out_brt_nxt   = div_q[BW-1:0];
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ibhn_pkg::ST_CLEAR;
      clr_idx_r    <= '0;
      sw_idx_r     <= '0;
      max_weight_r <= '0;
      obj_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) obj_count_r <= cfg_object_count;
      if (state_r == ibhn_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (accept && in_action == ibhn_pkg::ACT_CLEAR) clr_idx_r <= '0;
      if (accept && in_action == ibhn_pkg::ACT_SWEEP) begin
        sw_idx_r     <= '0;
        max_weight_r <= '0;
      end
      if (state_r == ibhn_pkg::ST_SW_WR) begin
        sw_idx_r <= sw_idx_r + IDX_W'(1);
        if (weight_r > max_weight_r) max_weight_r <= weight_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_brt_r <= out_brt_nxt;
    if (accept) pix_addr_r <= pix_obj[IDX_W-1:0];
    if (accept && in_action == ibhn_pkg::ACT_READ) req_idx_r <= in_object_index;
    if (state_r == ibhn_pkg::ST_SW_MUL) begin
      cnt_val_r <= cnt_rdata;
      r2_r      <= R2W'(rad_rdata) * R2W'(rad_rdata);
    end
    if (state_r == ibhn_pkg::ST_SW_START) weight_r <= WW'(cnt_val_r);
    if (state_r == ibhn_pkg::ST_SW_DIV && div_done) weight_r <= q_sat;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = req_idx_r;
  assign out_brightness   = out_brt_r;

  ibhn_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_OBJECTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ibhn_ram #(
    .WIDTH (ibhn_pkg::RAD_W),
    .DEPTH (MAX_OBJECTS)
  ) u_rad_ram (
    .clk   (clk),
    .we    (rad_we),
    .waddr (IDX_W'(in_object_index)),
    .wdata (in_radius),
    .raddr (sw_idx_r),
    .rdata (rad_rdata)
  );

  ibhn_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_OBJECTS)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (sw_idx_r),
    .wdata (weight_r),
    .raddr (IDX_W'(in_object_index)),
    .rdata (wgt_rdata)
  );

  ibhn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  a_pix_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibhn_pkg::ST_PIX) |->
      $past(start && !busy && in_action == ibhn_pkg::ACT_PIXEL))
    else $error("counter write-back without a pixel request");

  a_peak_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ibhn_pkg::ST_IDLE && !(start && in_action == ibhn_pkg::ACT_SWEEP)) |=>
      $stable(max_weight_r))
    else $error("peak weight changed outside a sweep");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ibhn_pkg::ST_RD_CHK || state_r == ibhn_pkg::ST_RD_DIV ||
                          (start && !busy && in_action == ibhn_pkg::ACT_READ)))
    else $error("result strobe without a read request");

  a_nonzero_needs_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_brt_r != '0) |-> (max_weight_r != '0))
    else $error("non-zero brightness with zero peak");

endmodule

// File: hw/rtl/ibhn_ram.sv
module ibhn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ibhn_div.sv
module ibhn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ibhn_pkg::DIV_N-1:0]  dividend,
  input  logic [ibhn_pkg::WGT_W-1:0]  divisor,
  output logic                        done,
  output logic [ibhn_pkg::DIV_N-1:0]  quotient
);

  localparam int DN  = ibhn_pkg::DIV_N;
  localparam int WW  = ibhn_pkg::WGT_W;
  localparam int SCW = $clog2(DN);
  localparam logic [SCW-1:0] STEP_LAST = SCW'(DN - 1);

  logic           run_r;
  logic           done_r;
  logic [SCW-1:0] step_r;
  logic [WW-1:0]  rem_r;
  logic [WW-1:0]  den_r;
  logic [DN-1:0]  q_r;
  logic [WW:0]    sh;
  logic           ge;
  logic [WW-1:0]  rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh      = {rem_r, q_r[DN-1]};
    ge      = sh >= {1'b0, den_r};
    rem_nxt = ge ? WW'(sh - {1'b0, den_r}) : sh[WW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + SCW'(1);
        if (step_r == STEP_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= divisor;
      q_r   <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DN-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
